### rtl/iss_pkg.sv
// Package: shared types, operation and status codes for the integer stack with search.
package iss_pkg;

  // Default number of stack entries
  localparam int DEPTH_DEFAULT = 64;

  // Operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Value reported for an empty stack or a pop on empty
  localparam logic signed [31:0] NEG_ONE = -32'sd1;

  // Command transfer payload
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } cmd_t;

  // Result transfer payload
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic               found;
    logic               is_empty;
    logic               is_full;
    logic [1:0]         status;
  } result_t;

endpackage

### rtl/integer_stack_with_search.sv
// Top level: bounded LIFO stack of signed 32-bit integers with a membership search.
//
// Usage:
//   Commands enter on cmd (func, value) and transfer on a rising edge where start
//   is high and busy is low. Each command produces exactly one result on result,
//   shown for one cycle with done high; the receiver cannot hold results off.
// Completion:
//   push, func code 3, pop that leaves the stack empty or that finds it empty,
//   search on an empty stack: done is high in the cycle after the transfer, and
//   busy stays low, so these run one per cycle.
//   pop that leaves entries: the new top is read through the registered read port
//   of the entry memory and taken in state S_POP, which raises done.
//   search: scans entries until the first match (at most the entry count); the
//   scan reads one entry per cycle through the single memory read port.
//   Busy is high while a pop read or a scan runs.
// Reset (rst, synchronous, active high) empties the stack and drops any command
// in flight; no clearing pass is needed since only entries below the count are read.
module integer_stack_with_search #(
  parameter int DEPTH = iss_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  iss_pkg::cmd_t    cmd,
  output logic             done,
  output iss_pkg::result_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  // Controller state codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_POP    = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]         state;
  logic [CW-1:0]      count;
  logic signed [31:0] top;
  logic signed [31:0] key;
  logic [AW-1:0]      scan_idx;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic               accept;
  logic               is_full_now;
  logic               is_empty_now;
  logic [CW-1:0]      count_dec;

  assign busy         = (state != S_IDLE);
  assign accept       = start && (state == S_IDLE);
  assign is_full_now  = (count == CNT_FULL);
  assign is_empty_now = (count == '0);
  assign count_dec    = count - CNT_ONE;
  assign wr_en        = accept && (cmd.func == iss_pkg::OP_PUSH) && !is_full_now;

  // Pick read address: new top on pop, scan position otherwise
  always_comb begin
    if (state == S_IDLE) begin
      if (cmd.func == iss_pkg::OP_POP) begin
        rd_addr = AW'(count - CNT_TWO);
      end else begin
        rd_addr = '0;
      end
    end else begin
      rd_addr = scan_idx + AW'(1);
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= cmd.value;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequence commands, update count and cached top, build results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result.popped_value <= '0;
            result.top_value    <= is_empty_now ? iss_pkg::NEG_ONE : top;
            result.found        <= 1'b0;
            result.is_empty     <= is_empty_now;
            result.is_full      <= is_full_now;
            result.status       <= iss_pkg::ST_OK;
            key                 <= cmd.value;
            scan_idx            <= '0;
            done                <= 1'b1;
            case (cmd.func)
              iss_pkg::OP_PUSH: begin
                if (is_full_now) begin
                  result.status <= iss_pkg::ST_FULL;
                end else begin
                  top              <= cmd.value;
                  count            <= count + CNT_ONE;
                  result.top_value <= cmd.value;
                  result.is_empty  <= 1'b0;
                  result.is_full   <= (count + CNT_ONE == CNT_FULL);
                end
              end
              iss_pkg::OP_POP: begin
                if (is_empty_now) begin
                  result.popped_value <= iss_pkg::NEG_ONE;
                  result.status       <= iss_pkg::ST_EMPTY;
                end else begin
                  result.popped_value <= top;
                  result.is_full      <= 1'b0;
                  count               <= count_dec;
                  if (count_dec == '0) begin
                    result.top_value <= iss_pkg::NEG_ONE;
                    result.is_empty  <= 1'b1;
                  end else begin
                    // wait for the new top from memory
                    done  <= 1'b0;
                    state <= S_POP;
                  end
                end
              end
              iss_pkg::OP_SEARCH: begin
                if (!is_empty_now) begin
                  done  <= 1'b0;
                  state <= S_SEARCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          top              <= rd_data;
          result.top_value <= rd_data;
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        S_SEARCH: begin
          // compare the entry at scan_idx; stop on a hit or at the top
          if (rd_data == key) begin
            result.found <= 1'b1;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (scan_idx == count_dec[AW-1:0]) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/iss_chk.sv
// Checker: port-level assertions for the integer stack with search, bound to the top level.
module iss_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input iss_pkg::result_t result
);

  // Every accepted command either reports next cycle or holds the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command neither reported nor went busy");

  // A fresh reset leaves the block idle with no result shown
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // An empty stack reports a top of -1
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.top_value == iss_pkg::NEG_ONE))
    else $error("empty stack reported a top other than -1");

  // A pop on empty returns -1 and leaves the stack empty
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == iss_pkg::ST_EMPTY)) |->
      ((result.popped_value == iss_pkg::NEG_ONE) && result.is_empty))
    else $error("underflow result inconsistent");

  // Empty and full never show together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.is_empty && result.is_full))
    else $error("empty and full both set");

endmodule

bind integer_stack_with_search iss_chk u_iss_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### test/integer_stack_with_search_test.sv
// Testbench for integer_stack_with_search: a command driver, a result monitor and a shadow stack.
`timescale 1ns / 100ps

module integer_stack_with_search_test;

  localparam int DEPTH = iss_pkg::DEPTH_DEFAULT;
  localparam int ITEM_TARGET = 850;
  localparam int CALM_TAIL = 120;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    iss_pkg::cmd_t payload;
    int            idle_after;
    bit            wait_drained;
  } pending_cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  iss_pkg::cmd_t    cmd = '0;
  logic             busy;
  logic             done;
  iss_pkg::result_t result;

  pending_cmd_t     pending_cmds[$];
  iss_pkg::result_t expected_results[$];

  // Shadow copy of the stack contents
  logic signed [31:0] shadow_vals[DEPTH];
  int shadow_count = 0;

  int queued_items = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int n_push = 0, n_pop = 0, n_search = 0, n_search_hit = 0;
  int n_full_drop = 0, n_empty_pop = 0, n_noop = 0;

  integer_stack_with_search #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow stack and return the result it should produce
  function automatic iss_pkg::result_t apply_stack_op(iss_pkg::cmd_t c);
    iss_pkg::result_t r;
    r = '0;
    r.popped_value = '0;
    case (c.func)
      iss_pkg::OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = iss_pkg::ST_FULL;
          n_full_drop++;
        end else begin
          shadow_vals[shadow_count] = c.value;
          shadow_count++;
          n_push++;
        end
      end
      iss_pkg::OP_POP: begin
        if (shadow_count == 0) begin
          r.popped_value = iss_pkg::NEG_ONE;
          r.status = iss_pkg::ST_EMPTY;
          n_empty_pop++;
        end else begin
          shadow_count--;
          r.popped_value = shadow_vals[shadow_count];
          n_pop++;
        end
      end
      iss_pkg::OP_SEARCH: begin
        for (int i = 0; i < shadow_count; i++)
          if (shadow_vals[i] == c.value) r.found = 1'b1;
        n_search++;
        if (r.found) n_search_hit++;
      end
      default: n_noop++;
    endcase
    r.top_value = (shadow_count == 0) ? iss_pkg::NEG_ONE : shadow_vals[shadow_count - 1];
    r.is_empty = (shadow_count == 0);
    r.is_full = (shadow_count >= DEPTH);
    return r;
  endfunction

  // Favor a small pool of values so that searches hit, with full-range values mixed in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0000_0001;
      5: return 32'h0000_002A;
      6: return 32'hDEAD_BEEF;
      7: return 32'hFFFF_FF00;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [1:0] f, logic [31:0] v, int idle_after, bit wait_drained);
    pending_cmd_t p;
    p.payload.func = f;
    p.payload.value = v;
    p.idle_after = idle_after;
    p.wait_drained = wait_drained;
    pending_cmds.push_back(p);
    queued_items++;
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 field, results_seen, want, got);
    end
  endtask

  // Drive commands; hold start until the transfer, then idle as the item asks
  always @(posedge clk) begin : driver
    logic          next_start;
    iss_pkg::cmd_t next_cmd;
    int            idle_left;
    next_start = start;
    next_cmd = cmd;
    if (rst) begin
      next_start = 1'b0;
      idle_left = 0;
    end else if (!start || !busy) begin
      next_start = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending_cmds.size() != 0) begin
        // hold a draining item until no result is outstanding
        if (!(pending_cmds[0].wait_drained && (start || expected_results.size() != 0))) begin
          next_cmd = pending_cmds[0].payload;
          idle_left = pending_cmds[0].idle_after;
          next_start = 1'b1;
          void'(pending_cmds.pop_front());
        end
      end
    end
    start <= next_start;
    cmd <= next_cmd;
  end

  // Check each result against the oldest expectation, then predict any new transfer
  always @(posedge clk) begin : monitor
    iss_pkg::result_t want;
    if (rst) begin
      shadow_count = 0;
    end else begin
      if (done) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected: %p", results_seen, result);
        end else begin
          want = expected_results.pop_front();
          check_field("popped_value", want.popped_value, result.popped_value);
          check_field("top_value", want.top_value, result.top_value);
          check_field("found", want.found, result.found);
          check_field("is_empty", want.is_empty, result.is_empty);
          check_field("is_full", want.is_full, result.is_full);
          check_field("status", want.status, result.status);
        end
      end
      if (start && !busy) expected_results.push_back(apply_stack_op(cmd));
    end
  end

  // Stop a hung run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int  phase_kind, phase_len, roll, gap, settle;
    bit  idle_phase;
    logic [1:0] f;

    // Directed: empty-stack cases, value extremes, a held -1 and the unused code
    queue_cmd(iss_pkg::OP_POP, 32'h1234_5678, 0, 1'b0);
    queue_cmd(iss_pkg::OP_SEARCH, 32'h0000_0000, 0, 1'b0);
    queue_cmd(OP_UNUSED, 32'hFFFF_FFFF, 3, 1'b0);
    queue_cmd(iss_pkg::OP_PUSH, 32'h8000_0000, 0, 1'b0);
    queue_cmd(iss_pkg::OP_PUSH, 32'h7FFF_FFFF, 0, 1'b0);
    queue_cmd(iss_pkg::OP_PUSH, 32'hFFFF_FFFF, 0, 1'b0);
    queue_cmd(iss_pkg::OP_PUSH, 32'h0000_0000, 5, 1'b0);
    queue_cmd(iss_pkg::OP_SEARCH, 32'h8000_0000, 0, 1'b0);
    queue_cmd(iss_pkg::OP_SEARCH, 32'h0000_0000, 0, 1'b0);
    queue_cmd(iss_pkg::OP_SEARCH, 32'h7FFF_FFFF, 2, 1'b0);
    queue_cmd(iss_pkg::OP_SEARCH, 32'h0000_3039, 0, 1'b0);
    queue_cmd(OP_UNUSED, 32'h5555_5555, 0, 1'b0);
    queue_cmd(iss_pkg::OP_POP, 32'hAAAA_AAAA, 0, 1'b0);
    queue_cmd(iss_pkg::OP_POP, 32'h0000_0000, 1, 1'b0);
    queue_cmd(iss_pkg::OP_POP, 32'hFFFF_FFFF, 0, 1'b0);
    queue_cmd(iss_pkg::OP_POP, 32'h0000_0000, 0, 1'b0);
    queue_cmd(iss_pkg::OP_POP, 32'h0000_0000, 0, 1'b0);
    queue_cmd(iss_pkg::OP_SEARCH, 32'hFFFF_FFFF, 0, 1'b0);

    // Fill to full, overflow, scan a full stack, then refill the freed slot
    for (int i = 0; i < DEPTH + 2; i++)
      queue_cmd(iss_pkg::OP_PUSH, pick_value(),
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0, (i == 0));
    queue_cmd(iss_pkg::OP_SEARCH, 32'h5A5A_0001, 0, 1'b0);
    queue_cmd(OP_UNUSED, $urandom, 0, 1'b0);
    queue_cmd(iss_pkg::OP_POP, $urandom, 0, 1'b0);
    queue_cmd(iss_pkg::OP_PUSH, pick_value(), 0, 1'b0);
    queue_cmd(iss_pkg::OP_PUSH, pick_value(), 0, 1'b0);

    // Random phases biased toward growing, shrinking or churning the stack
    while (queued_items < ITEM_TARGET) begin
      phase_kind = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 90);
      idle_phase = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < phase_len && queued_items < ITEM_TARGET; i++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          0: f = (roll < 60) ? iss_pkg::OP_PUSH : (roll < 75) ? iss_pkg::OP_POP :
                 (roll < 95) ? iss_pkg::OP_SEARCH : OP_UNUSED;
          1: f = (roll < 15) ? iss_pkg::OP_PUSH : (roll < 75) ? iss_pkg::OP_POP :
                 (roll < 95) ? iss_pkg::OP_SEARCH : OP_UNUSED;
          default:
            f = (roll < 35) ? iss_pkg::OP_PUSH : (roll < 65) ? iss_pkg::OP_POP :
                (roll < 95) ? iss_pkg::OP_SEARCH : OP_UNUSED;
        endcase
        gap = 0;
        if (idle_phase && queued_items < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 3) == 0)
          gap = $urandom_range(1, 18);
        queue_cmd(f, (f == iss_pkg::OP_POP) ? $urandom : pick_value(), gap,
                  (i == 0) && ($urandom_range(0, 3) == 0));
      end
    end

    // Release reset and let the driver run the queue dry
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    settle = 0;
    while (expected_results.size() != 0 && settle < 4 * DEPTH + 100) begin
      @(posedge clk);
      settle++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("covered %0d commands in %0d cycles: %0d pushes, %0d pops, %0d unused codes",
             queued_items, cycle_count, n_push, n_pop, n_noop);
    $display("  %0d searches (%0d hits), %0d pushes dropped full, %0d pops on empty",
             n_search, n_search_hit, n_full_drop, n_empty_pop);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
